// File: rtl/core/icp_pkg.sv
// Shared constants for the Mahonian number (inversion count) unit.
// No dependencies; imported by inversion_count_permutations_unit.
package icp_pkg;

    // Field widths of the query and result transfers
    localparam int ELEM_W  = 4;
    localparam int INV_W   = 7;
    localparam int COUNT_W = 29;

    // Width of one row store word
    localparam int WORD_W  = 32;

    // Parameter defaults
    localparam int DEF_MAX_ELEMENTS    = 12;
    localparam int DEF_INVERSION_DEPTH = 128;

    // Upper bound on any count the unit can return for n up to 12 (12!)
    localparam logic [COUNT_W-1:0] MAX_COUNT = 29'd479001600;

endpackage

// File: rtl/core/inversion_count_permutations_unit.sv
// Mahonian number unit: counts permutations of n elements with k inversions.
// Depends on icp_pkg (widths, defaults).
//
// Each query transfer (n, k) returns one result T(n,k), the number of permutations
// of n elements with exactly k inversions. A query with n above MAX_ELEMENTS or k at
// or above INVERSION_DEPTH returns 0; n = 0 returns 1 for k = 0 and 0otherwise.
// The unit builds the table row by row in two ping-pong row banks, cells 0..k only,
// using one shared add/subtract unit that keeps a running window sum, one cell per
// cycle. A query with 1 <= n in range issues k+1 cells per row, each row followed by
// a drain state, and the last row's result is then loaded into the output register;
// other queries go straight to the output register. s_ready is high only while no
// query is in work; a finished result sits in the output register until taken, and
// a new result waits for it.
module inversion_count_permutations_unit
    import icp_pkg::*;
#(
    parameter int MAX_ELEMENTS    = DEF_MAX_ELEMENTS,
    parameter int INVERSION_DEPTH = DEF_INVERSION_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [ELEM_W-1:0]  s_element_count,
    input  logic [INV_W-1:0]   s_inversion_count,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COUNT_W-1:0] m_permutation_count
);

    localparam int AW = $clog2(INVERSION_DEPTH);
    localparam int IW = (AW > ELEM_W) ? AW : ELEM_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ROW    = 4'b0010,
        ST_GAP    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       i_reg, i_next;
    logic [ELEM_W-1:0]   j_reg, j_next;
    logic [ELEM_W-1:0]   n_reg, n_next;
    logic [AW-1:0]       k_reg, k_next;
    logic                src_reg, src_next;
    logic [WORD_W-1:0]   win_reg, win_next;
    logic [COUNT_W-1:0]  res_reg, res_next;
    logic                p_valid_reg, p_valid_next;
    logic [AW-1:0]       p_idx_reg, p_idx_next;
    logic                p_sub_reg, p_sub_next;
    logic                p_last_reg, p_last_next;
    logic                m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;

    // Row banks and their registered read data
    logic [WORD_W-1:0]   bank0_mem [INVERSION_DEPTH];
    logic [WORD_W-1:0]   bank1_mem [INVERSION_DEPTH];
    logic [WORD_W-1:0]   rd0_a_reg, rd0_b_reg, rd1_a_reg, rd1_b_reg;
    logic [AW-1:0]       rd_addr_a, rd_addr_b;
    logic                wr_en0, wr_en1;

    logic [WORD_W-1:0]   rd_a, rd_b, cell_val;
    logic                first_row;
    logic                in_range;

    // Query range check
    assign in_range = (s_element_count <= ELEM_W'(MAX_ELEMENTS))
                   && (32'(s_inversion_count) < 32'(INVERSION_DEPTH));

    // Read addresses: current cell and the cell leaving the window
    assign rd_addr_a = i_reg;
    assign rd_addr_b = i_reg - AW'(j_reg);

    // Writes go to the bank not being read
    assign wr_en0 = p_valid_reg && src_reg;
    assign wr_en1 = p_valid_reg && !src_reg;

    always_ff @(posedge aclk) begin
        if (wr_en0) begin
            bank0_mem[p_idx_reg] <= cell_val;
        end
        rd0_a_reg <= bank0_mem[rd_addr_a];
        rd0_b_reg <= bank0_mem[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (wr_en1) begin
            bank1_mem[p_idx_reg] <= cell_val;
        end
        rd1_a_reg <= bank1_mem[rd_addr_a];
        rd1_b_reg <= bank1_mem[rd_addr_b];
    end

    // Shared window-sum unit: new cell = window + entering - leaving
    assign rd_a      = src_reg ? rd1_a_reg : rd0_a_reg;
    assign rd_b      = src_reg ? rd1_b_reg : rd0_b_reg;
    assign first_row = (j_reg == ELEM_W'(1));

    always_comb begin
        if (first_row) begin
            // row 1 is the unit row: 1 at cell 0, 0 elsewhere
            cell_val = WORD_W'(p_idx_reg == '0);
        end else begin
            cell_val = win_reg + rd_a - (p_sub_reg ? rd_b : '0);
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        src_next     = src_reg;
        win_next     = win_reg;
        res_next     = res_reg;
        p_valid_next = 1'b0;
        p_idx_next   = p_idx_reg;
        p_sub_next   = p_sub_reg;
        p_last_next  = p_last_reg;
        m_valid_next = m_valid_reg;
        m_count_next = m_count_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // data stage of the cell in flight
        if (p_valid_reg) begin
            win_next = cell_val;
            if (p_last_reg && (j_reg == n_reg)) begin
                res_next = cell_val[COUNT_W-1:0];
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    n_next = s_element_count;
                    k_next = AW'(s_inversion_count);
                    if (in_range && (s_element_count != '0)) begin
                        j_next     = ELEM_W'(1);
                        i_next     = '0;
                        win_next   = '0;
                        src_next   = 1'b0;
                        state_next = ST_ROW;
                    end else begin
                        res_next   = COUNT_W'(in_range && (s_inversion_count == '0));
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_ROW: begin
                p_valid_next = 1'b1;
                p_idx_next   = i_reg;
                p_sub_next   = (IW'(i_reg) >= IW'(j_reg));
                p_last_next  = (i_reg == k_reg);
                if (i_reg == k_reg) begin
                    state_next = ST_GAP;
                end else begin
                    i_next = i_reg + AW'(1);
                end
            end
            ST_GAP: begin
                // last cell of the row drains; next row starts afresh
                if (j_reg == n_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    j_next     = j_reg + ELEM_W'(1);
                    src_next   = !src_reg;
                    i_next     = '0;
                    win_next   = '0;
                    state_next = ST_ROW;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_count_next = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        n_reg       <= n_next;
        k_reg       <= k_next;
        src_reg     <= src_next;
        win_reg     <= win_next;
        res_reg     <= res_next;
        p_idx_reg   <= p_idx_next;
        p_sub_reg   <= p_sub_next;
        p_last_reg  <= p_last_next;
        m_count_reg <= m_count_next;
    end

    assign s_ready             = (state_reg == ST_IDLE);
    assign m_valid             = m_valid_reg;
    assign m_permutation_count = m_count_reg;

    // No cell in flight while a new query may be taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !p_valid_reg)
        else $error("cell in flight while idle");

    // Issue index never passes the requested inversion count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROW) |-> (i_reg <= k_reg))
        else $error("cell index beyond k");

    // Row counter stays within the requested element count
    assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg |-> ((j_reg != '0) && (j_reg <= n_reg)))
        else $error("row counter out of range");

    // A delivered count never exceeds 12!
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_permutation_count <= MAX_COUNT))
        else $error("count out of range");

endmodule
